// ----- hdl/assert_macros.svh -----
// assertion macros used by the top level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop, msg)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

// ----- hdl/gcm_pkg.sv -----
// shared types and constants of the glob component matcher
`timescale 1ns / 1ps
`default_nettype none

package gcm_pkg;

   localparam int PATTERN_DEPTH_DEF = 64;
   localparam int NAME_DEPTH_DEF    = 256;

   localparam logic OPC_PATTERN = 1'b0;
   localparam logic OPC_NAME    = 1'b1;

   localparam logic [1:0] KIND_EXACT = 2'd0;
   localparam logic [1:0] KIND_GLOB  = 2'd1;
   localparam logic [1:0] KIND_ANY   = 2'd2;

   localparam logic [7:0] CH_QMARK  = 8'h3F;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_BANG   = 8'h21;
   localparam logic [7:0] CH_DASH   = 8'h2D;
   localparam logic [7:0] CH_RBRACK = 8'h5D;

   typedef enum logic [3:0] {
      W_IDLE,
      W_GLOB,
      W_CLS_NEG,
      W_CLS_A,
      W_CLS_B,
      W_CLS_C,
      W_TAIL,
      W_EXACT,
      W_DONE
   } gcm_state_type;

   typedef struct packed {
      logic       start;
      logic [1:0] mode;
      logic       ovf;
   } gcm_job_type;

   typedef struct packed {
      logic idle;
      logic done;
      logic matched;
   } gcm_res_type;

endpackage

`default_nettype wire

// ----- hdl/gcm_walker.sv -----
// pattern and name stores with the match sequencer
`timescale 1ns / 1ps
`default_nettype none

module gcm_walker
   import gcm_pkg::*;
#(
   parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF,
   parameter int NAME_DEPTH    = NAME_DEPTH_DEF,
   localparam int PAW = $clog2(PATTERN_DEPTH),
   localparam int NAW = $clog2(NAME_DEPTH),
   localparam int PW  = $clog2(PATTERN_DEPTH + 1),
   localparam int NW  = $clog2(NAME_DEPTH + 1)
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           pat_we,
   input  wire logic [PAW-1:0] pat_waddr,
   input  wire logic [7:0]     pat_wdata,
   input  wire logic           name_we,
   input  wire logic [NAW-1:0] name_waddr,
   input  wire logic [7:0]     name_wdata,
   input  wire gcm_job_type    job,
   input  wire logic [PW-1:0]  plen,
   input  wire logic [NW-1:0]  nlen,
   input  wire logic           res_ack,
   output gcm_res_type         res
);

   logic [7:0] pat_mem  [PATTERN_DEPTH];
   logic [7:0] name_mem [NAME_DEPTH];
   logic [7:0] pat_q_ff;
   logic [7:0] name_q_ff;

   gcm_state_type state_ff, state_in;
   logic [PW-1:0] p_ff, p_in, star_p_ff, star_p_in;
   logic [NW-1:0] s_ff, s_in, star_s_ff, star_s_in;
   logic          star_valid_ff, star_valid_in;
   logic          neg_ff, neg_in, hit_ff, hit_in;
   logic [7:0]    c_ff, c_in, a_ff, a_in;
   logic          matched_ff, matched_in;
   logic          p_lt;

   // read data always belongs to the current index registers
   always_ff @(posedge clock) begin
      if (pat_we) begin
         pat_mem[pat_waddr] <= pat_wdata;
      end
      pat_q_ff <= pat_mem[p_in[PAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (name_we) begin
         name_mem[name_waddr] <= name_wdata;
      end
      name_q_ff <= name_mem[s_in[NAW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= W_IDLE;
         p_ff          <= '0;
         s_ff          <= '0;
         star_valid_ff <= 1'b0;
         matched_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         p_ff          <= p_in;
         s_ff          <= s_in;
         star_valid_ff <= star_valid_in;
         matched_ff    <= matched_in;
      end
   end

   always_ff @(posedge clock) begin
      star_p_ff <= star_p_in;
      star_s_ff <= star_s_in;
      neg_ff    <= neg_in;
      hit_ff    <= hit_in;
      c_ff      <= c_in;
      a_ff      <= a_in;
   end

   always_comb begin
      state_in      = state_ff;
      p_in          = p_ff;
      s_in          = s_ff;
      star_p_in     = star_p_ff;
      star_s_in     = star_s_ff;
      star_valid_in = star_valid_ff;
      neg_in        = neg_ff;
      hit_in        = hit_ff;
      c_in          = c_ff;
      a_in          = a_ff;
      matched_in    = matched_ff;
      p_lt          = (p_ff < plen);

      case (state_ff)
         W_IDLE: begin
            if (job.start) begin
               p_in          = '0;
               s_in          = '0;
               star_valid_in = 1'b0;
               matched_in    = 1'b0;
               if (job.ovf) begin
                  state_in = W_DONE;
               end else if (job.mode == KIND_ANY) begin
                  matched_in = 1'b1;
                  state_in   = W_DONE;
               end else if (job.mode == KIND_EXACT) begin
                  state_in = (32'(plen) == 32'(nlen)) ? W_EXACT : W_DONE;
               end else if (job.mode == KIND_GLOB) begin
                  state_in = W_GLOB;
               end else begin
                  state_in = W_DONE;
               end
            end
         end
         W_EXACT: begin
            if (!p_lt) begin
               matched_in = 1'b1;
               state_in   = W_DONE;
            end else if (pat_q_ff != name_q_ff) begin
               state_in = W_DONE;
            end else begin
               p_in = p_ff + 1'b1;
               s_in = s_ff + 1'b1;
            end
         end
         W_GLOB: begin
            if (s_ff >= nlen) begin
               state_in = W_TAIL;
            end else if (p_lt && (pat_q_ff == CH_QMARK || pat_q_ff == name_q_ff)) begin
               p_in = p_ff + 1'b1;
               s_in = s_ff + 1'b1;
            end else if (p_lt && pat_q_ff == CH_STAR) begin
               star_valid_in = 1'b1;
               star_p_in     = p_ff;
               star_s_in     = s_ff;
               p_in          = p_ff + 1'b1;
            end else if (p_lt && pat_q_ff == CH_LBRACK) begin
               c_in     = name_q_ff;
               hit_in   = 1'b0;
               p_in     = p_ff + 1'b1;
               state_in = W_CLS_NEG;
            end else if (star_valid_ff) begin
               p_in      = star_p_ff + 1'b1;
               star_s_in = star_s_ff + 1'b1;
               s_in      = star_s_ff + 1'b1;
            end else begin
               state_in = W_DONE;
            end
         end
         W_CLS_NEG: begin
            neg_in   = p_lt && (pat_q_ff == CH_BANG);
            state_in = W_CLS_A;
            if (p_lt && pat_q_ff == CH_BANG) begin
               p_in = p_ff + 1'b1;
            end
         end
         W_CLS_A: begin
            if (p_lt && pat_q_ff != CH_RBRACK) begin
               a_in     = pat_q_ff;
               p_in     = p_ff + 1'b1;
               state_in = W_CLS_B;
            end else begin
               // class closed or pattern ran out
               state_in = W_GLOB;
               if (hit_ff == neg_ff) begin
                  if (!star_valid_ff) begin
                     state_in = W_DONE;
                  end else begin
                     p_in      = star_p_ff + 1'b1;
                     star_s_in = star_s_ff + 1'b1;
                     s_in      = star_s_ff + 1'b1;
                  end
               end else begin
                  s_in = s_ff + 1'b1;
                  if (p_lt) begin
                     p_in = p_ff + 1'b1;
                  end
               end
            end
         end
         W_CLS_B: begin
            if (p_lt && pat_q_ff == CH_DASH) begin
               p_in     = p_ff + 1'b1;
               state_in = W_CLS_C;
            end else begin
               if (c_ff == a_ff) begin
                  hit_in = 1'b1;
               end
               state_in = W_CLS_A;
            end
         end
         W_CLS_C: begin
            state_in = W_CLS_A;
            if (p_lt && pat_q_ff != CH_RBRACK) begin
               if (c_ff >= a_ff && c_ff <= pat_q_ff) begin
                  hit_in = 1'b1;
               end
               p_in = p_ff + 1'b1;
            end else begin
               // dash taken as a literal, rescan from it
               if (c_ff == a_ff) begin
                  hit_in = 1'b1;
               end
               p_in = p_ff - 1'b1;
            end
         end
         W_TAIL: begin
            if (p_lt && pat_q_ff == CH_STAR) begin
               p_in = p_ff + 1'b1;
            end else begin
               matched_in = (p_ff == plen);
               state_in   = W_DONE;
            end
         end
         W_DONE: begin
            if (res_ack) begin
               state_in = W_IDLE;
            end
         end
         default: begin
            state_in = W_IDLE;
         end
      endcase
   end

   assign res.idle    = (state_ff == W_IDLE);
   assign res.done    = (state_ff == W_DONE);
   assign res.matched = matched_ff;

endmodule

`default_nettype wire

// ----- hdl/glob_component_matcher.sv -----
// top level of the glob component matcher
//
//  channel | ports     | direction | contents
//  --------+-----------+-----------+--------------------------------------------
//  request | req_*     | in        | pattern or name byte, kind on last pattern
//  result  | rsp_*     | out       | matched and overflow, one per name
//
// pattern and name requests are taken one per cycle, back to back, while no
// walk is pending; bytes go straight into the stores
// after the last name request the input stalls through the start handoff, the
// walk and the done state; exact walks up to length+1 steps when the lengths
// agree and none otherwise; glob advances one step per cycle, a class element
// passing W_CLS_A, W_CLS_B and, after a dash, W_CLS_C, and star backtracking
// can revisit up to pattern length times name length steps
// synchronous reset clears lengths, flags and the sequencer; no clearing pass
// a finished walk waits in done, still stalling requests, while the result
// register is full and not taken
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module glob_component_matcher
   import gcm_pkg::*;
#(
   parameter int PATTERN_DEPTH = PATTERN_DEPTH_DEF,
   parameter int NAME_DEPTH    = NAME_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // char_byte [7:0]
   input  wire logic [3:0]  req_tuser,   // opcode [0], has_char [1], pattern_kind [3:2]
   input  wire logic        req_tlast,   // is_last
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [7:0]       rsp_tdata    // matched [0], overflow [1], zeros
);

   localparam int PAW = $clog2(PATTERN_DEPTH);
   localparam int NAW = $clog2(NAME_DEPTH);
   localparam int PW  = $clog2(PATTERN_DEPTH + 1);
   localparam int NW  = $clog2(NAME_DEPTH + 1);

   // request fields
   logic       acc;
   logic       is_name;
   logic       has_char;
   logic [7:0] char_byte;
   logic [1:0] kind;

   // pattern side
   logic [PW-1:0] pat_len_ff, pat_len_in, pat_len_base;
   logic [1:0]    pat_mode_ff, pat_mode_in;
   logic          pat_over_ff, pat_over_in, pat_over_base;
   logic          pat_closed_ff, pat_closed_in;
   logic          pat_room, pat_we;

   // name side
   logic [NW-1:0] name_len_ff, name_len_in, name_len_next;
   logic          name_ovf_ff, name_ovf_in, name_ovf_next;
   logic          name_room, name_we;

   // job handed to the sequencer
   logic          go_ff, go_in;
   logic [NW-1:0] job_nlen_ff, job_nlen_in;
   logic          job_ovf_ff, job_ovf_in;
   logic          last_name;
   gcm_job_type   job;
   gcm_res_type   res;
   logic          res_load;

   // result register
   logic rsp_tvalid_ff, rsp_tvalid_in;
   logic rsp_matched_ff, rsp_matched_in;
   logic rsp_overflow_ff, rsp_overflow_in;

   assign char_byte = req_tdata;
   assign kind      = req_tuser[3:2];
   assign is_name   = (req_tuser[0] == OPC_NAME);
   assign has_char  = req_tuser[1];

   // hold requests from the last name until the sequencer is idle again
   assign req_tready = !go_ff && res.idle;
   assign acc        = req_tvalid && req_tready;
   assign last_name  = acc && is_name && req_tlast;

   always_comb begin
      // a pattern request after a closed pattern starts a new one
      pat_len_base  = pat_closed_ff ? '0 : pat_len_ff;
      pat_over_base = pat_closed_ff ? 1'b0 : pat_over_ff;
      pat_room      = (32'(pat_len_base) < PATTERN_DEPTH);
      pat_we        = acc && !is_name && has_char && pat_room;

      pat_len_in    = pat_len_ff;
      pat_over_in   = pat_over_ff;
      pat_mode_in   = pat_mode_ff;
      pat_closed_in = pat_closed_ff;
      if (acc && !is_name) begin
         pat_len_in    = pat_len_base + PW'(pat_we);
         pat_over_in   = pat_over_base || (has_char && !pat_room);
         pat_closed_in = 1'b0;
         if (req_tlast) begin
            pat_mode_in   = kind;
            pat_closed_in = 1'b1;
         end
      end

      name_room     = (32'(name_len_ff) < NAME_DEPTH);
      name_we       = acc && is_name && has_char && name_room;
      name_len_next = name_len_ff + NW'(name_we);
      name_ovf_next = name_ovf_ff || (has_char && !name_room);

      name_len_in = name_len_ff;
      name_ovf_in = name_ovf_ff;
      job_nlen_in = job_nlen_ff;
      job_ovf_in  = job_ovf_ff;
      if (acc && is_name) begin
         name_len_in = name_len_next;
         name_ovf_in = name_ovf_next;
         if (req_tlast) begin
            // snapshot the name for the walk, then start the next name empty
            job_nlen_in = name_len_next;
            job_ovf_in  = name_ovf_next || pat_over_ff;
            name_len_in = '0;
            name_ovf_in = 1'b0;
         end
      end

      // sequencer takes the job in the first cycle it is idle
      go_in = (go_ff && !res.idle) || last_name;
   end

   assign job.start = go_ff;
   assign job.mode  = pat_mode_ff;
   assign job.ovf   = job_ovf_ff;

   // result register: load when the walk is done and the slot is free
   always_comb begin
      res_load        = res.done && (!rsp_tvalid_ff || rsp_tready);
      rsp_tvalid_in   = rsp_tvalid_ff;
      rsp_matched_in  = rsp_matched_ff;
      rsp_overflow_in = rsp_overflow_ff;
      if (res_load) begin
         rsp_tvalid_in   = 1'b1;
         rsp_matched_in  = res.matched;
         rsp_overflow_in = job_ovf_ff;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pat_len_ff    <= '0;
         pat_mode_ff   <= KIND_EXACT;
         pat_over_ff   <= 1'b0;
         pat_closed_ff <= 1'b1;
         name_len_ff   <= '0;
         name_ovf_ff   <= 1'b0;
         go_ff         <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         pat_len_ff    <= pat_len_in;
         pat_mode_ff   <= pat_mode_in;
         pat_over_ff   <= pat_over_in;
         pat_closed_ff <= pat_closed_in;
         name_len_ff   <= name_len_in;
         name_ovf_ff   <= name_ovf_in;
         go_ff         <= go_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_nlen_ff     <= job_nlen_in;
      job_ovf_ff      <= job_ovf_in;
      rsp_matched_ff  <= rsp_matched_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   gcm_walker #(
      .PATTERN_DEPTH (PATTERN_DEPTH),
      .NAME_DEPTH    (NAME_DEPTH)
   ) u_walker (
      .clock      (clock),
      .reset      (reset),
      .pat_we     (pat_we),
      .pat_waddr  (pat_len_base[PAW-1:0]),
      .pat_wdata  (char_byte),
      .name_we    (name_we),
      .name_waddr (name_len_ff[NAW-1:0]),
      .name_wdata (char_byte),
      .job        (job),
      .plen       (pat_len_ff),
      .nlen       (job_nlen_ff),
      .res_ack    (res_load),
      .res        (res)
   );

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = {6'b0, rsp_overflow_ff, rsp_matched_ff};

   // checks
   `ASSERT_ALWAYS(a_pat_len_bound, clock, reset, 32'(pat_len_ff) <= PATTERN_DEPTH, "pattern length beyond store")
   `ASSERT_ALWAYS(a_name_len_bound, clock, reset, 32'(name_len_ff) <= NAME_DEPTH, "name length beyond store")
   `ASSERT_IMPLY(a_ovf_no_match, clock, reset, rsp_tvalid_ff, !(rsp_matched_ff && rsp_overflow_ff), "overflow result marked as match")
   `ASSERT_NEXT(a_hold_after_name, clock, reset, last_name, !req_tready, "request taken while walk pending")
   `ASSERT_IMPLY(a_load_from_walk, clock, reset, $rose(rsp_tvalid_ff), $past(res.done), "result without finished walk")

endmodule

`default_nettype wire

// ----- test/glob_component_matcher_tb.sv -----
// self-checking testbench for the glob component matcher
`timescale 1ns / 1ps

module glob_component_matcher_tb
   import gcm_pkg::*;
();

   // clock, reset and run length
   localparam int HALF_PERIOD  = 5;
   localparam int RESET_CYCLES = 7;
   localparam int RANDOM_ITEMS = 1550;
   // long glob walks with star backtracking cost the most,
   // so a handful of full-size cases dominate the slowest legal run
   localparam int CYCLE_LIMIT  = 2000000;
   localparam int TAIL_CYCLES  = 200;

   localparam int PAT_DEPTH = PATTERN_DEPTH_DEF;
   localparam int NM_DEPTH  = NAME_DEPTH_DEF;

   // kind 3 is stored but never matches
   localparam logic [1:0] KIND_UNUSED = 2'd3;
   localparam logic [7:0] LETTER_LO   = 8'h61;

   typedef logic [7:0] byte_q_type [$];

   // one request as the sender sees it; hold_for_drain makes the sender
   // wait until every pending result has come back before showing it
   typedef struct {
      logic       opcode;
      logic [7:0] char_byte;
      logic       has_char;
      logic       is_last;
      logic [1:0] pattern_kind;
      bit         hold_for_drain;
   } gcm_req_type;

   typedef struct packed {
      logic overflow;
      logic matched;
   } gcm_verdict_type;

   typedef enum logic [1:0] {
      READY_ALWAYS,
      READY_COIN,
      READY_SPARSE,
      READY_PERIODIC
   } ready_mode_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata  = '0;   // char_byte [7:0]
   logic [3:0]  req_tuser  = '0;   // opcode [0], has_char [1], pattern_kind [3:2]
   logic        req_tlast  = 1'b0; // is_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;         // matched [0], overflow [1], zeros

   // pending requests and the verdicts still owed by the block
   gcm_req_type     req_q [$];
   gcm_verdict_type verdicts_due [$];

   int mismatches  = 0;
   int cycle_count = 0;

   // shadow copy of the matcher state
   logic [7:0] pat_mem [PAT_DEPTH];
   logic [7:0] nm_mem  [NM_DEPTH];
   int         pat_len    = 0;
   int         nm_len     = 0;
   logic [1:0] pat_kind   = KIND_EXACT;
   bit         pat_ovf    = 1'b0;
   bit         nm_ovf     = 1'b0;
   bit         pat_closed = 1'b1;   // empty exact pattern after reset

   glob_component_matcher dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #HALF_PERIOD clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   // ---------------------------------------------------------------
   // prediction
   // ---------------------------------------------------------------

   // exact mode: same length and same bytes
   function automatic bit exact_equal();
      int i;
      if (nm_len != pat_len) return 1'b0;
      for (i = 0; i < pat_len; i++)
         if (nm_mem[i] != pat_mem[i]) return 1'b0;
      return 1'b1;
   endfunction

   // glob walk with one remembered star; a literal hit is tried first,
   // so a pattern byte equal to the name byte wins over star or bracket
   function automatic bit glob_accepts();
      int         p, s, star_p, star_s;
      bit         star_seen, neg, hit;
      logic [7:0] c;
      p = 0;
      s = 0;
      star_seen = 1'b0;
      star_p = 0;
      star_s = 0;
      while (s < nm_len) begin
         c = nm_mem[s];
         if (p < pat_len && (pat_mem[p] == CH_QMARK || pat_mem[p] == c)) begin
            p++;
            s++;
         end else if (p < pat_len && pat_mem[p] == CH_STAR) begin
            star_seen = 1'b1;
            star_p = p;
            star_s = s;
            p++;
         end else if (p < pat_len && pat_mem[p] == CH_LBRACK) begin
            hit = 1'b0;
            p++;
            neg = (p < pat_len && pat_mem[p] == CH_BANG);
            if (neg) p++;
            // a closing bracket right after the opener ends the class at once;
            // an unclosed class runs to the end of the pattern
            while (p < pat_len && pat_mem[p] != CH_RBRACK) begin
               if (p + 1 < pat_len && pat_mem[p + 1] == CH_DASH &&
                   p + 2 < pat_len && pat_mem[p + 2] != CH_RBRACK) begin
                  if (c >= pat_mem[p] && c <= pat_mem[p + 2]) hit = 1'b1;
                  p += 3;
               end else begin
                  // dash before the bracket or at the end is literal
                  if (c == pat_mem[p]) hit = 1'b1;
                  p++;
               end
            end
            if (p < pat_len && pat_mem[p] == CH_RBRACK) p++;
            if (hit == neg) begin
               if (!star_seen) return 1'b0;
               p = star_p + 1;
               star_s++;
               s = star_s;
            end else begin
               s++;
            end
         end else if (star_seen) begin
            p = star_p + 1;
            star_s++;
            s = star_s;
         end else begin
            return 1'b0;
         end
      end
      while (p < pat_len && pat_mem[p] == CH_STAR) p++;
      return p == pat_len;
   endfunction

   // fold one accepted request into the shadow state, owe a verdict on
   // the last name request
   task automatic advance_matcher(input gcm_req_type r);
      gcm_verdict_type v;
      if (r.opcode == OPC_PATTERN) begin
         // first request after a closed pattern starts a new one
         if (pat_closed) begin
            pat_len = 0;
            pat_ovf = 1'b0;
            pat_closed = 1'b0;
         end
         if (r.has_char) begin
            if (pat_len < PAT_DEPTH) begin
               pat_mem[pat_len] = r.char_byte;
               pat_len++;
            end else begin
               pat_ovf = 1'b1;
            end
         end
         if (r.is_last) begin
            pat_kind = r.pattern_kind;
            pat_closed = 1'b1;
         end
      end else begin
         if (r.has_char) begin
            if (nm_len < NM_DEPTH) begin
               nm_mem[nm_len] = r.char_byte;
               nm_len++;
            end else begin
               nm_ovf = 1'b1;
            end
         end
         if (r.is_last) begin
            // an open pattern is matched as stored so far, old kind kept
            v.overflow = nm_ovf || pat_ovf;
            if (v.overflow) v.matched = 1'b0;
            else if (pat_kind == KIND_ANY) v.matched = 1'b1;
            else if (pat_kind == KIND_EXACT) v.matched = exact_equal();
            else if (pat_kind == KIND_GLOB) v.matched = glob_accepts();
            else v.matched = 1'b0;
            verdicts_due.push_back(v);
            nm_len = 0;
            nm_ovf = 1'b0;
         end
      end
   endtask

   // ---------------------------------------------------------------
   // stimulus helpers
   // ---------------------------------------------------------------

   function automatic logic [7:0] random_letter();
      return LETTER_LO + 8'($urandom_range(0, 4));
   endfunction

   function automatic byte_q_type random_letters(input int n);
      byte_q_type q;
      repeat (n) q.push_back(random_letter());
      return q;
   endfunction

   function automatic byte_q_type text_of(input string s);
      byte_q_type q;
      int         i;
      for (i = 0; i < s.len(); i++) q.push_back(s[i]);
      return q;
   endfunction

   // short glob-flavored pattern over a small alphabet so matches happen
   function automatic byte_q_type random_pattern(input int len);
      byte_q_type q;
      int         r, k;
      while (q.size() < len) begin
         r = $urandom_range(0, 99);
         if (r < 50) begin
            q.push_back(random_letter());
         end else if (r < 60) begin
            q.push_back(CH_QMARK);
         end else if (r < 72) begin
            q.push_back(CH_STAR);
         end else if (r < 86) begin
            // bracket class: optional negation, letters, ranges, bare dashes
            q.push_back(CH_LBRACK);
            if ($urandom_range(0, 2) == 0) q.push_back(CH_BANG);
            k = $urandom_range(0, 3);
            repeat (k) begin
               case ($urandom_range(0, 3))
                  0: begin
                     q.push_back(random_letter());
                     q.push_back(CH_DASH);
                     q.push_back(random_letter());
                  end
                  1: q.push_back(CH_DASH);
                  default: q.push_back(random_letter());
               endcase
            end
            if ($urandom_range(0, 9) != 0) q.push_back(CH_RBRACK);
         end else if (r < 93) begin
            case ($urandom_range(0, 2))
               0: q.push_back(CH_BANG);
               1: q.push_back(CH_DASH);
               default: q.push_back(CH_RBRACK);
            endcase
         end else begin
            q.push_back(8'($urandom_range(0, 255)));
         end
      end
      return q;
   endfunction

   // a name that the pattern should roughly accept, then maybe disturbed
   function automatic byte_q_type name_for(input byte_q_type pat);
      byte_q_type q;
      int         i, r;
      i = 0;
      while (i < pat.size()) begin
         if (pat[i] == CH_STAR) begin
            repeat ($urandom_range(0, 3)) q.push_back(random_letter());
         end else if (pat[i] == CH_QMARK) begin
            q.push_back(random_letter());
         end else if (pat[i] == CH_LBRACK) begin
            q.push_back(random_letter());
            while (i + 1 < pat.size() && pat[i + 1] != CH_RBRACK) i++;
            i++;
         end else begin
            q.push_back(pat[i]);
         end
         i++;
      end
      r = $urandom_range(0, 9);
      if (r < 2 && q.size() > 0) q[$urandom_range(0, q.size() - 1)] = random_letter();
      else if (r == 2) q.insert($urandom_range(0, q.size()), random_letter());
      else if (r == 3 && q.size() > 0) q.delete($urandom_range(0, q.size() - 1));
      return q;
   endfunction

   task automatic queue_one(input logic opc, input logic [7:0] ch, input logic has,
                            input logic last, input logic [1:0] kind);
      gcm_req_type r;
      r.opcode = opc;
      r.char_byte = ch;
      r.has_char = has;
      r.is_last = last;
      r.pattern_kind = kind;
      r.hold_for_drain = 1'b0;
      req_q.push_back(r);
   endtask

   // one pattern or name as requests; noisy adds empty filler requests and
   // sometimes closes the string with a separate empty last request
   task automatic queue_text(input logic opc, input byte_q_type text, input logic [1:0] kind,
                             input bit noisy);
      int i, n;
      bit pad_end;
      n = text.size();
      pad_end = noisy && ($urandom_range(0, 9) == 0);
      for (i = 0; i < n; i++) begin
         if (noisy && $urandom_range(0, 11) == 0)
            queue_one(opc, 8'($urandom_range(0, 255)), 1'b0, 1'b0, 2'($urandom_range(0, 3)));
         if (i == n - 1 && !pad_end)
            queue_one(opc, text[i], 1'b1, 1'b1, kind);
         else
            queue_one(opc, text[i], 1'b1, 1'b0, 2'($urandom_range(0, 3)));
      end
      if (n == 0 || pad_end)
         queue_one(opc, 8'($urandom_range(0, 255)), 1'b0, 1'b1, kind);
   endtask

   // ---------------------------------------------------------------
   // request driver: bursts of random length, random gaps between them
   // ---------------------------------------------------------------
   int          burst_left = 0;
   int          gap_left   = 0;
   gcm_req_type sent;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            sent = req_q.pop_front();
            advance_matcher(sent);
         end
         if (req_tvalid && !req_tready) begin
            // request stays on the bus until taken
         end else if (req_q.size() == 0) begin
            req_tvalid <= 1'b0;
         end else if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (req_q[0].hold_for_drain && verdicts_due.size() != 0) begin
            // pause until the block has returned every owed result
            req_tvalid <= 1'b0;
         end else begin
            req_tvalid <= 1'b1;
            req_tdata  <= req_q[0].char_byte;
            req_tuser  <= {req_q[0].pattern_kind, req_q[0].has_char, req_q[0].opcode};
            req_tlast  <= req_q[0].is_last;
            if (burst_left == 0) begin
               burst_left = $urandom_range(1, 48);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end else begin
               burst_left--;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // result monitor: own stall pattern, compare against oldest verdict
   // ---------------------------------------------------------------
   ready_mode_type  ready_mode  = READY_ALWAYS;
   int              ready_span  = 0;
   gcm_verdict_type due;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (verdicts_due.size() == 0) begin
               $error("result with no verdict owed: tdata %h", rsp_tdata);
               mismatches++;
            end else begin
               due = verdicts_due.pop_front();
               if (rsp_tdata[0] !== due.matched) begin
                  $error("matched: expected %0d, actual %0b", due.matched, rsp_tdata[0]);
                  mismatches++;
               end
               if (rsp_tdata[1] !== due.overflow) begin
                  $error("overflow: expected %0d, actual %0b", due.overflow, rsp_tdata[1]);
                  mismatches++;
               end
            end
         end
         // switch stall style when the random span runs out
         if (ready_span == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            ready_span = $urandom_range(20, 200);
         end else begin
            ready_span--;
         end
         case (ready_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_COIN:   rsp_tready <= 1'($urandom_range(0, 1));
            READY_SPARSE: rsp_tready <= ($urandom_range(0, 7) == 0);
            default:      rsp_tready <= (cycle_count[3:0] >= 4'd5);
         endcase
      end
   end

   // ---------------------------------------------------------------
   // timeout
   // ---------------------------------------------------------------
   initial begin
      wait (cycle_count >= CYCLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
   end

   // ---------------------------------------------------------------
   // stimulus, reset and end of run
   // ---------------------------------------------------------------
   initial begin
      byte_q_type pat, nm;
      int         step, mark, bulk, n_names, r, plen;
      logic [1:0] kind;

      // directed part
      // empty name against the empty exact pattern left by reset
      queue_text(OPC_NAME, text_of(""), KIND_EXACT, 1'b0);
      // lone bracket equals the name byte before it opens a class
      queue_text(OPC_PATTERN, text_of("["), KIND_GLOB, 1'b0);
      queue_text(OPC_NAME, text_of("["), KIND_EXACT, 1'b0);
      // question mark, star, unclosed class at the end
      queue_text(OPC_PATTERN, text_of("?*["), KIND_GLOB, 1'b0);
      queue_text(OPC_NAME, text_of("ab"), KIND_EXACT, 1'b0);
      // high byte range compares unsigned
      pat = '{CH_LBRACK, 8'h80, CH_DASH, 8'hFF, CH_RBRACK};
      queue_text(OPC_PATTERN, pat, KIND_GLOB, 1'b0);
      queue_one(OPC_NAME, 8'hFF, 1'b1, 1'b1, KIND_UNUSED);
      queue_one(OPC_NAME, 8'h00, 1'b1, 1'b1, KIND_EXACT);
      // closing bracket right after negation closes the class
      queue_text(OPC_PATTERN, text_of("[!]a"), KIND_GLOB, 1'b0);
      queue_text(OPC_NAME, text_of("xa"), KIND_EXACT, 1'b0);
      // unused kind never matches
      queue_text(OPC_PATTERN, text_of("a"), KIND_UNUSED, 1'b0);
      queue_text(OPC_NAME, text_of("a"), KIND_EXACT, 1'b0);
      // name while the pattern is still open, then match-anything
      queue_one(OPC_PATTERN, 8'h62, 1'b1, 1'b0, KIND_GLOB);
      queue_text(OPC_NAME, text_of("b"), KIND_EXACT, 1'b0);
      queue_one(OPC_PATTERN, 8'h00, 1'b0, 1'b1, KIND_ANY);
      queue_text(OPC_NAME, text_of("zz"), KIND_EXACT, 1'b0);
      // zero byte is an ordinary character
      queue_one(OPC_PATTERN, 8'h00, 1'b1, 1'b1, KIND_EXACT);
      queue_one(OPC_NAME, 8'h00, 1'b1, 1'b1, KIND_ANY);

      // random part
      step = 0;
      bulk = 0;
      while (bulk < RANDOM_ITEMS) begin
         mark = req_q.size();
         if (step == 3) begin
            // full pattern store with stars against a full name store
            pat.delete();
            pat.push_back(CH_STAR);
            while (pat.size() < PAT_DEPTH)
               pat.push_back(($urandom_range(0, 7) == 0) ? CH_STAR : random_letter());
            queue_text(OPC_PATTERN, pat, KIND_GLOB, 1'b0);
            queue_text(OPC_NAME, random_letters(NM_DEPTH), KIND_EXACT, 1'b0);
         end else if (step == 5) begin
            // pattern one byte too long: overflow until the next pattern
            pat = random_letters(PAT_DEPTH + 1);
            queue_text(OPC_PATTERN, pat, KIND_EXACT, 1'b0);
            nm = pat[0:PAT_DEPTH-1];
            queue_text(OPC_NAME, nm, KIND_EXACT, 1'b0);
            queue_text(OPC_NAME, text_of(""), KIND_EXACT, 1'b0);
         end else if (step == 7) begin
            // name filling its store exactly, then one byte too long
            queue_text(OPC_PATTERN, text_of("*"), KIND_GLOB, 1'b0);
            queue_text(OPC_NAME, random_letters(NM_DEPTH), KIND_EXACT, 1'b0);
            queue_text(OPC_NAME, random_letters(NM_DEPTH + 1), KIND_EXACT, 1'b0);
            queue_text(OPC_NAME, text_of("ab"), KIND_EXACT, 1'b0);
         end else if (step == 9) begin
            // full exact pattern, equal name, then last byte differing
            pat = random_letters(PAT_DEPTH);
            queue_text(OPC_PATTERN, pat, KIND_EXACT, 1'b0);
            queue_text(OPC_NAME, pat, KIND_EXACT, 1'b0);
            nm = pat;
            nm[PAT_DEPTH-1] = ~nm[PAT_DEPTH-1];
            queue_text(OPC_NAME, nm, KIND_EXACT, 1'b0);
         end else if ($urandom_range(0, 9) == 0) begin
            // raw noise: any opcode, any field values
            repeat ($urandom_range(1, 6))
               queue_one(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                         2'($urandom_range(0, 3)));
         end else begin
            // well-formed pattern followed by a few names
            plen = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 8);
            pat = random_pattern(plen);
            r = $urandom_range(0, 99);
            if (r < 60) kind = KIND_GLOB;
            else if (r < 80) kind = KIND_EXACT;
            else if (r < 92) kind = KIND_ANY;
            else kind = KIND_UNUSED;
            queue_text(OPC_PATTERN, pat, kind, 1'b1);
            n_names = $urandom_range(1, 4);
            repeat (n_names) begin
               if ($urandom_range(0, 3) != 0) nm = name_for(pat);
               else nm = random_letters($urandom_range(0, 8));
               queue_text(OPC_NAME, nm, 2'($urandom_range(0, 3)), 1'b1);
            end
         end
         bulk += req_q.size() - mark;
         // now and then hold the sender until all results are back
         if (step % 150 == 1 && req_q.size() > mark) req_q[mark].hold_for_drain = 1'b1;
         step++;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // drain: everything sent and every verdict returned
      @(negedge clock);
      while (req_q.size() != 0 || req_tvalid || verdicts_due.size() != 0) @(negedge clock);
      // let any stray result show up
      repeat (TAIL_CYCLES) @(negedge clock);
      if (mismatches == 0 && verdicts_due.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
